[rtl/core/depq_pkg.sv]
// Package for the double-ended priority queue: sizes, codes, sequencer states
// and the request/response structs between the sequencer and the node store.
// No dependencies.
package depq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned POS_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT     = 2'd0,
    KIND_REMOVE_MAX = 2'd1,
    KIND_REMOVE_MIN = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_RM_RD,
    ST_RM_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_MN_RD,
    ST_MN_CMP,
    ST_MN_LD,
    ST_REP_SEL,
    ST_REP_RD,
    ST_REP_WR
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]        pa_addr;
    logic [IDX_W-1:0]        pb_addr;
    logic [IDX_W-1:0]        ma_addr;
    logic [IDX_W-1:0]        mb_addr;
    logic                    pw_en;
    logic [IDX_W-1:0]        pw_addr;
    logic signed [VAL_W-1:0] pw_data;
    logic                    mw_en;
    logic [IDX_W-1:0]        mw_addr;
    logic signed [VAL_W-1:0] mw_data;
  } mem_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pa;
    logic signed [VAL_W-1:0] pb;
    logic signed [VAL_W-1:0] ma;
    logic signed [VAL_W-1:0] mb;
  } mem_rsp_t;

  // Heap positions are 1-based; storage is 0-based.
  function automatic logic [IDX_W-1:0] pos_idx(input logic [POS_W:0] p);
    logic [POS_W:0] t;
    t = p - 1'b1;
    return t[IDX_W-1:0];
  endfunction

endpackage

[rtl/core/depq_if.sv]
// Valid/ready channel interfaces for the priority queue request and result.
// Depends on depq_pkg.
interface depq_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [depq_pkg::KIND_W-1:0]             kind;
  logic signed [depq_pkg::VAL_W-1:0]       value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface depq_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [depq_pkg::VAL_W-1:0]       removed;
  logic [depq_pkg::STATUS_W-1:0]           status;
  logic [depq_pkg::OCC_W-1:0]              occupancy;

  modport source (output valid, removed, status, occupancy, input ready);
  modport sink   (input valid, removed, status, occupancy, output ready);
endinterface

[rtl/core/depq_store.sv]
// Node storage: priority array and subtree-minimum array, each with two
// registered read ports and one write port. Depends on depq_pkg.
module depq_store (
  input  logic               clk_i,
  input  depq_pkg::mem_req_t req_i,
  output depq_pkg::mem_rsp_t rsp_o
);
  import depq_pkg::*;

  logic signed [VAL_W-1:0] prio_mem [CAPACITY];
  logic signed [VAL_W-1:0] min_mem  [CAPACITY];
  mem_rsp_t                rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.pw_en) begin
      prio_mem[req_i.pw_addr] <= req_i.pw_data;
    end
    if (req_i.mw_en) begin
      min_mem[req_i.mw_addr] <= req_i.mw_data;
    end
    rsp_q.pa <= prio_mem[req_i.pa_addr];
    rsp_q.pb <= prio_mem[req_i.pb_addr];
    rsp_q.ma <= min_mem[req_i.ma_addr];
    rsp_q.mb <= min_mem[req_i.mb_addr];
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/core/depq_ctrl.sv]
// Sequencer for the queue: sift up, sift down, minimum descent and minimum
// repair walks over the node store, plus the result register. Depends on depq_pkg.
module depq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [depq_pkg::KIND_W-1:0]   in_kind_i,
  input  logic signed [depq_pkg::VAL_W-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [depq_pkg::VAL_W-1:0] out_removed_o,
  output logic [depq_pkg::STATUS_W-1:0] out_status_o,
  output logic [depq_pkg::OCC_W-1:0]    out_occupancy_o,
  output depq_pkg::mem_req_t            req_o,
  input  depq_pkg::mem_rsp_t            rsp_i
);
  import depq_pkg::*;

  state_e                  state_q, state_d;
  logic [POS_W-1:0]        cnt_q, cnt_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [POS_W-1:0]        node_q, node_d;
  logic [POS_W-1:0]        repa_q, repa_d;
  logic [POS_W-1:0]        repb_q, repb_d;
  logic signed [VAL_W-1:0] cur_q, cur_d;
  logic signed [VAL_W-1:0] rem_q, rem_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_rem_q, out_rem_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [OCC_W-1:0]        out_occ_q, out_occ_d;

  logic                    accept;
  logic                    full, empty;
  logic [POS_W:0]          cnt_x, pos_x, node_x;
  logic [POS_W:0]          lpos, rpos, lnode, rnode;
  logic                    dn_right;
  logic signed [VAL_W-1:0] dn_val;
  logic [POS_W:0]          dn_pos;
  logic                    dn_move;
  logic                    up_move;
  logic                    rep_leaf;
  logic signed [VAL_W-1:0] rep_min;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q >= POS_W'(CAPACITY));
  assign empty      = (cnt_q == '0);

  assign cnt_x  = {1'b0, cnt_q};
  assign pos_x  = {1'b0, pos_q};
  assign node_x = {1'b0, node_q};
  assign lpos   = {pos_q, 1'b0};
  assign rpos   = {pos_q, 1'b1};
  assign lnode  = {node_q, 1'b0};
  assign rnode  = {node_q, 1'b1};

  // sift-down: larger child, right wins only on strictly greater
  assign dn_right = (rpos <= cnt_x) && (rsp_i.pb > rsp_i.pa);
  assign dn_val   = dn_right ? rsp_i.pb : rsp_i.pa;
  assign dn_pos   = dn_right ? rpos : lpos;
  assign dn_move  = (cur_q < dn_val);
  assign up_move  = (rsp_i.pa < cur_q);

  assign rep_leaf = (lnode > cnt_x);
  always_comb begin
    if (rep_leaf) begin
      rep_min = rsp_i.pa;
    end else if (rnode <= cnt_x) begin
      rep_min = (rsp_i.ma < rsp_i.mb) ? rsp_i.ma : rsp_i.mb;
    end else begin
      rep_min = rsp_i.ma;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_INSERT:     state_d = full  ? ST_IDLE : ST_UP_RD;
            KIND_REMOVE_MAX: state_d = empty ? ST_IDLE : ST_RM_RD;
            KIND_REMOVE_MIN: state_d = empty ? ST_IDLE : ST_MN_RD;
            default:         state_d = ST_IDLE;
          endcase
        end
      end
      ST_UP_RD:   state_d = (pos_q == POS_W'(1)) ? ST_REP_SEL : ST_UP_CMP;
      ST_UP_CMP:  state_d = up_move ? ST_UP_RD : ST_REP_SEL;
      ST_RM_RD:   state_d = ST_RM_LD;
      ST_RM_LD:   state_d = (cnt_q == POS_W'(1)) ? ST_REP_SEL : ST_DN_RD;
      ST_DN_RD:   state_d = (lpos > cnt_x) ? ST_REP_SEL : ST_DN_CMP;
      ST_DN_CMP:  state_d = dn_move ? ST_DN_RD : ST_REP_SEL;
      ST_MN_RD:   state_d = (pos_q <= (cnt_q >> 1)) ? ST_MN_CMP : ST_MN_LD;
      ST_MN_CMP:  state_d = ST_MN_RD;
      ST_MN_LD:   state_d = (pos_q != cnt_q) ? ST_UP_RD : ST_REP_SEL;
      ST_REP_SEL: state_d = (repa_q != '0 || repb_q != '0) ? ST_REP_RD : ST_IDLE;
      ST_REP_RD:  state_d = ST_REP_WR;
      ST_REP_WR:  state_d = (node_q == POS_W'(1)) ? ST_REP_SEL : ST_REP_RD;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath registers and store requests
  always_comb begin
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    node_d       = node_q;
    repa_d       = repa_q;
    repb_d       = repb_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rem_d    = out_rem_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    req_o        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_d = '0;
          case (in_kind_i)
            KIND_INSERT: begin
              if (full) begin
                out_valid_d  = 1'b1;
                out_rem_d    = '0;
                out_status_d = STATUS_FULL;
                out_occ_d    = OCC_W'(cnt_q);
              end else begin
                cnt_d  = cnt_q + 1'b1;
                pos_d  = cnt_q + 1'b1;
                repa_d = cnt_q + 1'b1;
                repb_d = '0;
                cur_d  = in_value_i;
              end
            end
            KIND_REMOVE_MAX, KIND_REMOVE_MIN: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_rem_d    = '0;
                out_status_d = STATUS_EMPTY;
                out_occ_d    = OCC_W'(cnt_q);
              end else begin
                pos_d = POS_W'(1);
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              out_rem_d    = '0;
              out_status_d = STATUS_OK;
              out_occ_d    = OCC_W'(cnt_q);
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos_q == POS_W'(1)) begin
          req_o.pw_en   = 1'b1;
          req_o.pw_addr = pos_idx(pos_x);
          req_o.pw_data = cur_q;
        end else begin
          req_o.pa_addr = pos_idx(pos_x >> 1);
        end
      end
      ST_UP_CMP: begin
        req_o.pw_en   = 1'b1;
        req_o.pw_addr = pos_idx(pos_x);
        if (up_move) begin
          req_o.pw_data = rsp_i.pa;
          pos_d         = pos_q >> 1;
        end else begin
          req_o.pw_data = cur_q;
        end
      end
      ST_RM_RD: begin
        req_o.pa_addr = pos_idx((POS_W+1)'(1));
        req_o.pb_addr = pos_idx(cnt_x);
      end
      ST_RM_LD: begin
        rem_d  = rsp_i.pa;
        cur_d  = rsp_i.pb;
        cnt_d  = cnt_q - 1'b1;
        repa_d = '0;
        repb_d = cnt_q >> 1;
      end
      ST_DN_RD: begin
        if (lpos > cnt_x) begin
          req_o.pw_en   = 1'b1;
          req_o.pw_addr = pos_idx(pos_x);
          req_o.pw_data = cur_q;
          repa_d        = pos_q;
        end else begin
          req_o.pa_addr = pos_idx(lpos);
          req_o.pb_addr = pos_idx(rpos);
        end
      end
      ST_DN_CMP: begin
        req_o.pw_en   = 1'b1;
        req_o.pw_addr = pos_idx(pos_x);
        if (dn_move) begin
          req_o.pw_data = dn_val;
          pos_d         = dn_pos[POS_W-1:0];
        end else begin
          req_o.pw_data = cur_q;
          repa_d        = pos_q;
        end
      end
      ST_MN_RD: begin
        if (pos_q <= (cnt_q >> 1)) begin
          req_o.ma_addr = pos_idx(pos_x);
          req_o.mb_addr = pos_idx(lpos);
        end else begin
          req_o.pa_addr = pos_idx(pos_x);
          req_o.pb_addr = pos_idx(cnt_x);
        end
      end
      ST_MN_CMP: begin
        // follow the child that holds the subtree minimum, left on a tie
        pos_d = (rsp_i.ma == rsp_i.mb) ? lpos[POS_W-1:0] : rpos[POS_W-1:0];
      end
      ST_MN_LD: begin
        rem_d  = rsp_i.pa;
        cur_d  = rsp_i.pb;
        cnt_d  = cnt_q - 1'b1;
        repb_d = cnt_q >> 1;
        repa_d = (pos_q != cnt_q) ? pos_q : '0;
      end
      ST_REP_SEL: begin
        if (repa_q != '0) begin
          node_d = repa_q;
          repa_d = '0;
        end else if (repb_q != '0) begin
          node_d = repb_q;
          repb_d = '0;
        end else begin
          out_valid_d  = 1'b1;
          out_rem_d    = rem_q;
          out_status_d = STATUS_OK;
          out_occ_d    = OCC_W'(cnt_q);
        end
      end
      ST_REP_RD: begin
        if (rep_leaf) begin
          req_o.pa_addr = pos_idx(node_x);
        end else begin
          req_o.ma_addr = pos_idx(lnode);
          req_o.mb_addr = pos_idx(rnode);
        end
      end
      ST_REP_WR: begin
        req_o.mw_en   = 1'b1;
        req_o.mw_addr = pos_idx(node_x);
        req_o.mw_data = rep_min;
        node_d        = node_q >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    node_q       <= node_d;
    repa_q       <= repa_d;
    repb_q       <= repb_d;
    cur_q        <= cur_d;
    rem_q        <= rem_d;
    out_rem_q    <= out_rem_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_removed_o   = out_rem_q;
  assign out_status_o    = out_status_q;
  assign out_occupancy_o = out_occ_q;

endmodule

[rtl/core/double_ended_priority_queue.sv]
// Double-ended priority queue of signed 32-bit values, up to 1024 entries, kept
// as a max-heap whose nodes also hold their subtree minimum. One request is
// worked at a time: insert, remove maximum or remove minimum, each answered by
// one result transaction with the removed value, a status and the occupancy.
// Every step of a sift or minimum repair is one read of the node store and one
// write; a step of the minimum descent is a read only. Errors and the unused
// request code present their result in the cycle after acceptance. The node
// store has two read ports and one write port per array.
// Depends on depq_pkg, depq_if, depq_store and depq_ctrl.
module double_ended_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  depq_in_if.sink     in_i,
  depq_out_if.source  out_o
);
  import depq_pkg::*;

  mem_req_t req;
  mem_rsp_t rsp;

  depq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_kind_i       (in_i.kind),
    .in_value_i      (in_i.value),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_removed_o   (out_o.removed),
    .out_status_o    (out_o.status),
    .out_occupancy_o (out_o.occupancy),
    .req_o           (req),
    .rsp_i           (rsp)
  );

  depq_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

endmodule

[tb/sv/tb_double_ended_priority_queue.sv]
// Testbench for double_ended_priority_queue: random and directed requests against
// a behavioral heap predictor, with random stalls on both channels.
// Depends on depq_pkg, depq_if and the block itself.
module tb_double_ended_priority_queue;
  import depq_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  removed;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  depq_in_if  in_ch ();
  depq_out_if out_ch ();

  double_ended_priority_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Predictor state, 1-based heap
  logic signed [VAL_W-1:0] pri_q [0:CAPACITY];
  logic signed [VAL_W-1:0] min_q [0:CAPACITY];
  int unsigned             count_q;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   mismatches;
  bit   stim_done;
  int   hold_cycles = 0;

  initial clk_i = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void swap_nodes(int unsigned a, int unsigned b);
    logic signed [VAL_W-1:0] t;
    t = pri_q[a]; pri_q[a] = pri_q[b]; pri_q[b] = t;
    t = min_q[a]; min_q[a] = min_q[b]; min_q[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned p);
    while (p > 1 && pri_q[p/2] < pri_q[p]) begin
      swap_nodes(p/2, p);
      p = p / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned c;
    while (2*p <= count_q) begin
      c = 2*p;
      if (c + 1 <= count_q && pri_q[c+1] > pri_q[c]) c = c + 1;
      if (pri_q[p] < pri_q[c]) swap_nodes(p, c);
      else break;
      p = c;
    end
  endfunction

  function automatic void refresh_minimums();
    int unsigned l;
    for (int unsigned i = count_q; i >= 1; i--) begin
      l = 2*i;
      if (l + 1 <= count_q)
        min_q[i] = (min_q[l] < min_q[l+1]) ? min_q[l] : min_q[l+1];
      else if (l <= count_q)
        min_q[i] = min_q[l];
      else
        min_q[i] = pri_q[i];
    end
  endfunction

  function automatic rsp_t predict_queue(req_t r);
    rsp_t        o;
    int unsigned i;
    o = '0;
    o.status = STATUS_OK;
    case (r.kind)
      KIND_INSERT: begin
        if (count_q >= CAPACITY) o.status = STATUS_FULL;
        else begin
          count_q++;
          pri_q[count_q] = r.value;
          min_q[count_q] = r.value;
          bubble_up(count_q);
          refresh_minimums();
        end
      end
      KIND_REMOVE_MAX: begin
        if (count_q == 0) o.status = STATUS_EMPTY;
        else begin
          o.removed = pri_q[1];
          pri_q[1] = pri_q[count_q];
          min_q[1] = min_q[count_q];
          count_q--;
          bubble_down(1);
          refresh_minimums();
        end
      end
      KIND_REMOVE_MIN: begin
        if (count_q == 0) o.status = STATUS_EMPTY;
        else begin
          i = 1;
          while (i <= count_q / 2) begin
            if (min_q[i] == min_q[2*i]) i = 2*i;
            else i = 2*i + 1;
          end
          o.removed = pri_q[i];
          swap_nodes(i, count_q);
          count_q--;
          if (i <= count_q) bubble_up(i);
          refresh_minimums();
        end
      end
      default: ;
    endcase
    o.occupancy = count_q[OCC_W-1:0];
    return o;
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(VAL_W'($urandom_range(0, 7)) - 32'd3);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic add_req(logic [KIND_W-1:0] k, logic signed [VAL_W-1:0] v);
    req_t r;
    r.kind = k;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  // Stimulus
  initial begin
    int n;
    int fill;
    add_req(KIND_REMOVE_MAX, 0);
    add_req(KIND_REMOVE_MIN, 0);
    add_req(2'd3, 32'sh12345678);
    add_req(KIND_INSERT, 32'sh7fffffff);
    add_req(KIND_INSERT, 32'sh80000000);
    add_req(KIND_INSERT, 0);
    add_req(KIND_INSERT, -1);
    add_req(KIND_INSERT, -1);
    add_req(KIND_INSERT, 5);
    add_req(KIND_REMOVE_MIN, 0);
    add_req(KIND_REMOVE_MAX, 0);
    add_req(KIND_REMOVE_MIN, 0);
    add_req(KIND_REMOVE_MIN, $signed(32'hffffffff));
    add_req(KIND_REMOVE_MAX, 0);
    add_req(KIND_REMOVE_MIN, 0);
    add_req(KIND_REMOVE_MAX, 0);
    // fill to capacity and beyond, then drain a little
    for (int i = 0; i < CAPACITY + 2; i++) add_req(KIND_INSERT, rand_value());
    for (int i = 0; i < 20; i++)
      add_req($urandom_range(0, 1) ? KIND_REMOVE_MIN : KIND_REMOVE_MAX, rand_value());
    // drain to about half full, then a random mix around that size
    n = 0;
    fill = CAPACITY - 18;
    while (n < 890) begin
      if (fill > 520) begin
        add_req($urandom_range(0, 1) ? KIND_REMOVE_MIN : KIND_REMOVE_MAX, rand_value());
        fill--;
      end else begin
        case ($urandom_range(0, 19))
          0: add_req(2'd3, rand_value());
          1, 2, 3, 4, 5, 6, 7, 8: begin
            add_req(KIND_INSERT, rand_value());
            fill++;
          end
          9, 10, 11, 12, 13: begin
            add_req(KIND_REMOVE_MAX, rand_value());
            if (fill > 0) fill--;
          end
          default: begin
            add_req(KIND_REMOVE_MIN, rand_value());
            if (fill > 0) fill--;
          end
        endcase
      end
      n++;
    end
  end

  initial begin
    rst_ni = 1'b0;
    count_q = 0;
    mismatches = 0;
    stim_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver
  int gap_cnt;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.value = '0;
    gap_cnt = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(predict_queue('{kind: in_ch.kind, value: in_ch.value}));
        void'(pending_reqs.pop_front());
        gap_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (pending_reqs.size() == 0) stim_done = 1'b1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // keep offering
      end else if (pending_reqs.size() != 0 && gap_cnt == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.kind  <= pending_reqs[0].kind;
        in_ch.value <= pending_reqs[0].value;
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_cnt > 0) gap_cnt--;
      end
    end
  end

  // Monitor and receiver stalls
  int stall_cnt;
  int rsp_seen;
  initial begin
    out_ch.ready = 1'b0;
    stall_cnt = 0;
    rsp_seen = 0;
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction");
        end else begin
          exp_r = expected_rsps.pop_front();
          if (out_ch.removed !== exp_r.removed || out_ch.status !== exp_r.status ||
              out_ch.occupancy !== exp_r.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp removed %0d status %0d occ %0d, got %0d %0d %0d",
                       exp_r.removed, exp_r.status, exp_r.occupancy,
                       out_ch.removed, out_ch.status, out_ch.occupancy);
          end
        end
        stall_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One long hold-off so the block backs up its input
  bit hold_armed;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_armed && rsp_seen >= 1500) begin
        hold_armed  <= 1'b1;
        hold_cycles <= 300;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/depq_pkg.sv
rtl/core/depq_if.sv
rtl/core/depq_store.sv
rtl/core/depq_ctrl.sv
rtl/core/double_ended_priority_queue.sv
tb/sv/tb_double_ended_priority_queue.sv
